// ===== design/round_robin_backend_selector_unit_macros.svh =====
// assertion macros for the backend selector
// no dependencies; included by the top level
`ifndef ROUND_ROBIN_BACKEND_SELECTOR_UNIT_MACROS_SVH
`define ROUND_ROBIN_BACKEND_SELECTOR_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication under synchronous active-low reset
`define RRBS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under synchronous active-low reset
`define RRBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define RRBS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RRBS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/rrbs_pkg.sv =====
// shared constants and codes for the backend selector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrbs_pkg;

    localparam int MAX_BACKENDS_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 4;
    localparam int CONN_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [CMD_W-1:0] CMD_REQ    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEALTH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [APB_AW-3:0] REG_NUM_BACKENDS = 1'b0;

endpackage

`default_nettype wire

// ===== design/rrbs_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rrbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                   i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/round_robin_backend_selector_unit.sv =====
// round-robin backend selector with alive mask and saturating connection counts
// depends on rrbs_pkg, rrbs_ram and the assertion macro header
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  cmd in  | in        | i_valid / o_ready  | i_cmd, i_backend_id
//  result  | out       | o_valid / i_ready  | o_backend_id_res, o_alive, o_connections,
//          |           |                    | o_status, o_last
//  config  | in        | apb psel / penable | paddr, pwdata, prdata, pready
//
// request: a scan past each backend that is down, then a count read, then the count write with the result beat
// mark-down: an address step, then a read step; health check: one result beat per active backend
// one index counter with a single increment-and-compare steps the scan and the sweep
// counts live in a small ram behind per-entry valid bits; no clearing pass after reset
// a finished beat waits in the output register; the sequencer holds while it is full
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_backend_selector_unit_macros.svh"

module round_robin_backend_selector_unit
    import rrbs_pkg::*;
#(
    parameter int MAX_BACKENDS = MAX_BACKENDS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [CMD_W-1:0]    i_cmd,
    input  wire logic [ID_W-1:0]     i_backend_id,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [ID_W-1:0]          o_backend_id_res,
    output logic                     o_alive,
    output logic [CONN_W-1:0]        o_connections,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_last,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int IDX_W = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int NW    = $clog2(MAX_BACKENDS + 1);
    localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
    localparam int XW    = (NW > ID_W) ? NW : ID_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REQ_RD,
        S_REQ_WR,
        S_NONE,
        S_MARK_AD,
        S_MARK_RD,
        S_HC
    } t_state;

    t_state                   r_state;
    logic [CFG_W-1:0]         r_num;
    logic [MAX_BACKENDS-1:0]  r_alive;
    logic [MAX_BACKENDS-1:0]  r_vld;
    logic [IDX_W-1:0]         r_ptr;
    logic [IDX_W-1:0]         r_idx;
    logic [NW-1:0]            r_scan;
    logic                     r_nf;
    logic [ID_W-1:0]          r_bid;
    logic [COUNT_WIDTH-1:0]   r_val;

    logic                     r_o_valid;
    logic [ID_W-1:0]          r_o_id;
    logic                     r_o_alive;
    logic [CONN_W-1:0]        r_o_conn;
    logic [STATUS_W-1:0]      r_o_status;
    logic                     r_o_last;

    logic [CW-1:0]            num_ext;
    logic [NW-1:0]            act_n;
    logic [NW-1:0]            idx_inc;
    logic                     idx_wrap;
    logic [IDX_W-1:0]         idx_nxt;
    logic [IDX_W-1:0]         start_idx;
    logic                     out_free;
    logic                     beat_load;
    logic [COUNT_WIDTH-1:0]   ram_rdata;
    logic [COUNT_WIDTH-1:0]   rd_cnt;
    logic                     ram_we;
    logic                     cfg_wr;

    // active backend count, clamped to 1..MAX_BACKENDS
    assign num_ext = CW'(r_num);
    assign act_n   = (num_ext == '0) ? NW'(1) :
                     (num_ext > CW'(MAX_BACKENDS)) ? NW'(MAX_BACKENDS) : NW'(num_ext);

    // the shared step: increment with wrap at the active count
    assign idx_inc   = NW'(r_idx) + NW'(1);
    assign idx_wrap  = (idx_inc >= act_n);
    assign idx_nxt   = idx_wrap ? '0 : IDX_W'(idx_inc);
    assign start_idx = (NW'(r_ptr) >= act_n) ? '0 : r_ptr;

    assign out_free  = !r_o_valid || i_ready;
    assign beat_load = out_free && (r_state inside {S_REQ_WR, S_NONE, S_MARK_RD, S_HC});
    assign rd_cnt    = r_vld[r_idx] ? ram_rdata : '0;
    assign ram_we    = (r_state == S_REQ_WR) && out_free;

    rrbs_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BACKENDS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_val),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // config port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_NUM_BACKENDS) ? APB_DW'(r_num) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num     <= CFG_W'(1);
            r_alive   <= '1;
            r_vld     <= '0;
            r_ptr     <= '0;
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[APB_AW-1:2] == REG_NUM_BACKENDS)) begin
                r_num <= pwdata[CFG_W-1:0];
            end
            if (i_ready && !beat_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_cmd)
                            CMD_REQ: begin
                                r_idx   <= start_idx;
                                r_scan  <= '0;
                                r_state <= S_SCAN;
                            end
                            CMD_DOWN: begin
                                r_bid   <= i_backend_id;
                                r_nf    <= (XW'(i_backend_id) >= XW'(act_n));
                                r_idx   <= IDX_W'(i_backend_id);
                                r_state <= S_MARK_AD;
                            end
                            CMD_HEALTH: begin
                                r_idx   <= '0;
                                r_state <= S_HC;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_alive[r_idx]) begin
                        r_ptr   <= idx_nxt;
                        r_state <= S_REQ_RD;
                    end else begin
                        r_idx  <= idx_nxt;
                        r_scan <= r_scan + NW'(1);
                        if (r_scan + NW'(1) == act_n) begin
                            r_ptr   <= idx_nxt;
                            r_state <= S_NONE;
                        end
                    end
                end
                S_REQ_RD: begin
                    r_val   <= (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
                    r_state <= S_REQ_WR;
                end
                S_REQ_WR: begin
                    if (out_free) begin
                        r_vld[r_idx] <= 1'b1;
                        r_o_valid    <= 1'b1;
                        r_o_id       <= ID_W'(r_idx);
                        r_o_alive    <= 1'b1;
                        r_o_conn     <= CONN_W'(r_val);
                        r_o_status   <= ST_OK;
                        r_o_last     <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_NONE: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_id     <= '0;
                        r_o_alive  <= 1'b0;
                        r_o_conn   <= '0;
                        r_o_status <= ST_NONE;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_MARK_AD: begin
                    r_state <= S_MARK_RD;
                end
                S_MARK_RD: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_id    <= r_bid;
                        r_o_alive <= 1'b0;
                        r_o_last  <= 1'b1;
                        if (r_nf) begin
                            r_o_conn   <= '0;
                            r_o_status <= ST_NOT_FOUND;
                        end else begin
                            r_alive[r_idx] <= 1'b0;
                            r_o_conn       <= CONN_W'(rd_cnt);
                            r_o_status     <= ST_OK;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_HC: begin
                    // a valid count is never zero, so valid means busy
                    if (out_free) begin
                        r_alive[r_idx] <= r_vld[r_idx];
                        r_vld[r_idx]   <= 1'b0;
                        r_o_valid      <= 1'b1;
                        r_o_id         <= ID_W'(r_idx);
                        r_o_alive      <= r_vld[r_idx];
                        r_o_conn       <= '0;
                        r_o_status     <= ST_OK;
                        r_o_last       <= idx_wrap;
                        if (idx_wrap) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= idx_nxt;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_backend_id_res = r_o_id;
    assign o_alive          = r_o_alive;
    assign o_connections    = r_o_conn;
    assign o_status         = r_o_status;
    assign o_last           = r_o_last;

    `RRBS_ASSERT_NXT(a_req_busy, i_clk, i_rst_n, i_valid && o_ready && (i_cmd == CMD_REQ), !o_ready, "request beat did not take the sequencer")
    `RRBS_ASSERT_IMP(a_hc_range, i_clk, i_rst_n, r_state == S_HC, NW'(r_idx) < act_n, "health sweep index past active count")
    `RRBS_ASSERT_IMP(a_none_beat, i_clk, i_rst_n, o_valid && (o_status == ST_NONE), o_last && !o_alive && (o_connections == '0), "no-backend beat carries data")

endmodule

`default_nettype wire

// ===== verif/tb_round_robin_backend_selector_unit.sv =====
// self-checking testbench for round_robin_backend_selector_unit
// depends on rrbs_pkg and the design sources; holds its own model of alive flags,
// counts and pointer, and checks every result beat in order against it
`timescale 1ns / 1ps

module tb_round_robin_backend_selector_unit;
    import rrbs_pkg::*;

    localparam int NB          = MAX_BACKENDS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = NB + 8;
    localparam int TAIL        = 2 * NB + 8;
    localparam int LIMIT       = 3000;
    localparam int SAT_BEATS   = 4;
    localparam int RAND_BEATS  = 80;

    localparam logic [CMD_W-1:0]  CMD_SPARE         = 2'd3;
    localparam logic [APB_AW-1:0] NUM_BACKENDS_ADDR = {REG_NUM_BACKENDS, 2'b00};

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic                alive;
        logic [CONN_W-1:0]   conn;
        logic [STATUS_W-1:0] status;
        logic                last;
    } sel_result_t;

    class selector_scoreboard;
        bit                alive_flag [NB];
        logic [CONN_W-1:0] conn_count [NB];
        int                rr_ptr;
        logic [CFG_W-1:0]  num_reg;
        sel_result_t       awaited [$];
        int                errors;

        function new();
            for (int i = 0; i < NB; i++) begin
                alive_flag[i] = 1'b1;
                conn_count[i] = '0;
            end
            rr_ptr  = 0;
            num_reg = CFG_W'(1);
            errors  = 0;
        endfunction

        function void set_backends(logic [CFG_W-1:0] value);
            num_reg = value;
        endfunction

        function int active();
            int n;
            n = num_reg;
            if (n < 1) n = 1;
            if (n > NB) n = NB;
            return n;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void queue_result(int id, bit alv, logic [CONN_W-1:0] conn,
                                   logic [STATUS_W-1:0] st, bit lst);
            sel_result_t r;
            r.id     = ID_W'(id);
            r.alive  = alv;
            r.conn   = conn;
            r.status = st;
            r.last   = lst;
            awaited = {awaited, r};
        endfunction

        function void take_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
            int n;
            int p;
            int cur;
            bit found;
            n     = active();
            found = 1'b0;
            case (cmd)
                CMD_REQ: begin
                    p = rr_ptr;
                    if (p >= n) p = 0;
                    for (int i = 0; i < n && !found; i++) begin
                        cur = p;
                        p   = (p + 1 >= n) ? 0 : p + 1;
                        if (alive_flag[cur]) begin
                            if (conn_count[cur] != '1) conn_count[cur] = conn_count[cur] + 1'b1;
                            queue_result(cur, 1'b1, conn_count[cur], ST_OK, 1'b1);
                            found = 1'b1;
                        end
                    end
                    rr_ptr = p;
                    if (!found) queue_result(0, 1'b0, '0, ST_NONE, 1'b1);
                end
                CMD_DOWN: begin
                    if (int'(id) >= n) begin
                        queue_result(id, 1'b0, '0, ST_NOT_FOUND, 1'b1);
                    end else begin
                        alive_flag[id] = 1'b0;
                        queue_result(id, 1'b0, conn_count[id], ST_OK, 1'b1);
                    end
                end
                CMD_HEALTH: begin
                    for (int i = 0; i < n; i++) begin
                        if (conn_count[i] != '0) begin
                            alive_flag[i] = 1'b1;
                            conn_count[i] = '0;
                        end else begin
                            alive_flag[i] = 1'b0;
                        end
                        queue_result(i, alive_flag[i], conn_count[i], ST_OK, i == n - 1);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sel_result_t got);
            sel_result_t want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: id %0d status %0d", got.id, got.status);
                errors++;
            end else begin
                want = awaited.pop_front();
                compare_field("backend_id_res", want.id, got.id);
                compare_field("alive", want.alive, got.alive);
                compare_field("connections", want.conn, got.conn);
                compare_field("status", want.status, got.status);
                compare_field("last", want.last, got.last);
            end
        endfunction
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                o_ready;
    logic [CMD_W-1:0]    i_cmd        = '0;
    logic [ID_W-1:0]     i_backend_id = '0;
    logic                o_valid;
    logic                i_ready      = 1'b0;
    logic [ID_W-1:0]     o_backend_id_res;
    logic                o_alive;
    logic [CONN_W-1:0]   o_connections;
    logic [STATUS_W-1:0] o_status;
    logic                o_last;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [APB_AW-1:0]   paddr        = '0;
    logic [APB_DW-1:0]   pwdata       = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    selector_scoreboard sb;
    bit          tx_idle_on  = 1'b0;
    bit          rx_idle_on  = 1'b0;
    int          hold_asked  = 0;
    int          hold_taken  = 0;
    int          hold_left   = 0;
    int          stall_left  = 0;
    int          quiet_count = 0;
    sel_result_t seen;

    round_robin_backend_selector_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_backend_id     (i_backend_id),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_backend_id_res (o_backend_id_res),
        .o_alive          (o_alive),
        .o_connections    (o_connections),
        .o_status         (o_status),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each beat, then decide next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen.id     = o_backend_id_res;
            seen.alive  = o_alive;
            seen.conn   = o_connections;
            seen.status = o_status;
            seen.last   = o_last;
            sb.check_result(seen);
        end
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
        int gap;
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_backend_id <= id;
        do @(posedge i_clk); while (!o_ready);
        sb.take_command(cmd, id);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering, wait for every awaited beat, then let the sequencer settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_backends(input logic [CFG_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NUM_BACKENDS_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_backends(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.compare_field("num_backends readback", value, prdata[CFG_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : main
        int beats;
        int round;
        int n;
        int reqs;
        int pick;
        logic [CFG_W-1:0] cfg;
        sb = new();
        beats = 0;
        round = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting of one backend, spare command ignored
        send_beat(CMD_REQ, 4'hf);
        send_beat(CMD_SPARE, 4'h0);
        send_beat(CMD_REQ, 4'h0);
        // a few more requests on the only backend
        for (int i = 0; i < SAT_BEATS; i++) send_beat(CMD_REQ, ID_W'(i));
        send_beat(CMD_HEALTH, 4'h0);

        write_backends(CFG_W'(16));
        send_beat(CMD_REQ, 4'h0);
        send_beat(CMD_REQ, 4'h5);
        send_beat(CMD_REQ, 4'ha);
        send_beat(CMD_DOWN, 4'hf);
        send_beat(CMD_DOWN, 4'h2);
        send_beat(CMD_REQ, 4'h0);

        // zero acts as one; pointer left beyond the range
        write_backends(CFG_W'(0));
        send_beat(CMD_DOWN, 4'h1);
        send_beat(CMD_REQ, 4'h3);
        send_beat(CMD_HEALTH, 4'hc);

        write_backends(CFG_W'(31));
        send_beat(CMD_DOWN, 4'hf);
        send_beat(CMD_REQ, 4'h9);

        // no alive backend, then revived by a sweep
        write_backends(CFG_W'(1));
        send_beat(CMD_REQ, 4'h0);
        send_beat(CMD_DOWN, 4'h0);
        send_beat(CMD_REQ, 4'hf);
        send_beat(CMD_HEALTH, 4'h0);

        while (beats < RAND_BEATS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       cfg = CFG_W'(0);
                1:       cfg = CFG_W'(31);
                2:       cfg = CFG_W'($urandom_range(17, 30));
                3:       cfg = CFG_W'(16);
                4:       cfg = CFG_W'(1);
                default: cfg = CFG_W'($urandom_range(2, 15));
            endcase
            write_backends(cfg);
            n    = sb.active();
            reqs = $urandom_range(n, n + 6);
            if (beats >= RAND_BEATS - 25) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            if (round == 0) begin
                // long hold on the result side while the sender keeps offering
                tx_idle_on = 1'b0;
                if (reqs < 10) reqs = 10;
                hold_asked++;
            end
            for (int i = 0; i < reqs; i++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_beat(CMD_SPARE, ID_W'($urandom));
                end else if (pick == 1) begin
                    send_beat(CMD_DOWN, ID_W'($urandom));
                    beats++;
                end
                send_beat(CMD_REQ, ID_W'($urandom));
                beats++;
            end
            if ($urandom_range(0, 1) == 0) begin
                send_beat(CMD_DOWN, ID_W'($urandom_range(0, n - 1)));
                beats++;
            end
            if ($urandom_range(0, 2) != 0) begin
                send_beat(CMD_HEALTH, ID_W'($urandom));
                beats++;
            end
            round++;
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/rrbs_pkg.sv
design/rrbs_ram.sv
design/round_robin_backend_selector_unit.sv
verif/tb_round_robin_backend_selector_unit.sv
